### rtl/lkvc_pkg.sv
// Shared constants, codes and controller/datapath types for the LRU key/value cache.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package lkvc_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_WIDTH   = 16;
    localparam int VALUE_WIDTH = 32;

    // capacity register
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    // update actions chosen by the controller
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE      = 3'd0;
    localparam t_act ACT_GET_HIT   = 3'd1;
    localparam t_act ACT_GET_MISS  = 3'd2;
    localparam t_act ACT_PUT_HIT   = 3'd3;
    localparam t_act ACT_PUT_NEW   = 3'd4;
    localparam t_act ACT_PUT_EVICT = 3'd5;

    typedef struct packed {
        logic capture;  // latch request, compare tags, read value memory
        logic apply;    // update stores and ranks, load result register
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic op;       // latched op: 1 = put
        logic hit;      // latched key matched a valid entry
        logic full;     // entry count has reached capacity
    } t_status;

endpackage

### rtl/lkvc_req_if.sv
// Request channel of the LRU key/value cache: op, key, value with valid/ready.
// Depends on lkvc_pkg for default widths.
interface lkvc_req_if #(
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic        [KEY_WIDTH-1:0]   key;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

### rtl/lkvc_rsp_if.sv
// Result channel of the LRU key/value cache: hit, read value and eviction report.
// Depends on lkvc_pkg for default widths.
interface lkvc_rsp_if #(
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic                          evicted;
    logic        [KEY_WIDTH-1:0]   evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### rtl/lkvc_cfg_if.sv
// Configuration write channel of the LRU key/value cache: capacity data with valid/ready.
// Depends on lkvc_pkg for the register width.
interface lkvc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lkvc_pkg::CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/lkvc_ctrl.sv
// Controller of the LRU key/value cache: request sequencing and result valid.
// Depends on lkvc_pkg for the command and status types.
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  lkvc_pkg::t_status i_status,
    output lkvc_pkg::t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    lkvc_pkg::t_act w_act;

    always_comb begin
        priority if (!i_status.op && i_status.hit) begin
            w_act = lkvc_pkg::ACT_GET_HIT;
        end else if (!i_status.op) begin
            w_act = lkvc_pkg::ACT_GET_MISS;
        end else if (i_status.hit) begin
            w_act = lkvc_pkg::ACT_PUT_HIT;
        end else if (i_status.full) begin
            w_act = lkvc_pkg::ACT_PUT_EVICT;
        end else begin
            w_act = lkvc_pkg::ACT_PUT_NEW;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid & ~i_rsp_ready;
        o_cmd.capture = 1'b0;
        o_cmd.apply   = 1'b0;
        o_cmd.act     = lkvc_pkg::ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                // finish only when the result register is free or being emptied
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.apply = 1'b1;
                    o_cmd.act   = w_act;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    a_apply_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_rsp_valid)
        else $error("result not presented after update");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |-> !o_cmd.apply)
        else $error("update overwrote a pending result");

    a_capture_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_req_ready)
        else $error("request accepted while another is in flight");

endmodule

### rtl/lkvc_dpath.sv
// Datapath of the LRU key/value cache: tag store, recency ranks, value memory, result register.
// Depends on lkvc_pkg for command/status types and action codes.
module lkvc_dpath #(
    parameter int ENTRIES     = lkvc_pkg::ENTRIES,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_op,
    input  logic        [KEY_WIDTH-1:0]   i_req_key,
    input  logic signed [VALUE_WIDTH-1:0] i_req_value,
    input  logic                          i_cfg_valid,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_data,
    input  lkvc_pkg::t_cmd                i_cmd,
    output lkvc_pkg::t_status             o_status,
    output logic                          o_hit,
    output logic signed [VALUE_WIDTH-1:0] o_read_value,
    output logic                          o_evicted,
    output logic        [KEY_WIDTH-1:0]   o_evicted_key
);

    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int EW     = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
    localparam int CAP_RS = (lkvc_pkg::CAP_RESET > ENTRIES) ? ENTRIES : lkvc_pkg::CAP_RESET;

    logic        [KEY_WIDTH-1:0]   r_key_store [ENTRIES];
    logic signed [VALUE_WIDTH-1:0] r_mem       [ENTRIES];
    logic        [IW-1:0]          r_rank      [ENTRIES];
    logic        [ENTRIES-1:0]     r_valid;
    logic        [CW-1:0]          r_count;
    logic        [CW-1:0]          r_cap_eff;

    // latched request and lookup results
    logic                          r_op;
    logic        [KEY_WIDTH-1:0]   r_key;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic                          r_hit;
    logic        [IW-1:0]          r_hit_idx;
    logic        [IW-1:0]          r_free_idx;
    logic        [IW-1:0]          r_victim_idx;
    logic signed [VALUE_WIDTH-1:0] r_rd_q;

    logic [ENTRIES-1:0] w_match;
    logic [IW-1:0]      w_match_idx;
    logic [IW-1:0]      w_free_idx;
    logic [IW-1:0]      w_victim_idx;
    logic [EW-1:0]      w_cap_in;
    logic [CW-1:0]      w_cap_clamped;
    logic [IW-1:0]      w_slot;
    logic [IW:0]        w_thr;
    logic               w_touch;
    logic               w_is_hit;
    logic               w_is_new;
    logic               w_is_evict;
    logic               w_is_put;

    // tag compare and slot search on the incoming key
    always_comb begin
        w_match_idx  = '0;
        w_free_idx   = '0;
        w_victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key_store[i] == i_req_key);
            if (w_match[i]) begin
                w_match_idx = w_match_idx | IW'(i);
            end
            // least recent entry holds rank count-1
            if (r_valid[i] && ((CW+1)'(r_rank[i]) == (CW+1)'(r_count) - (CW+1)'(1))) begin
                w_victim_idx = w_victim_idx | IW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_cap_in = EW'(i_cfg_data);
        if (w_cap_in == '0) begin
            w_cap_clamped = CW'(1);
        end else if (w_cap_in > EW'(ENTRIES)) begin
            w_cap_clamped = CW'(ENTRIES);
        end else begin
            w_cap_clamped = CW'(w_cap_in);
        end
    end

    assign w_is_hit   = (i_cmd.act == lkvc_pkg::ACT_GET_HIT) ||
                        (i_cmd.act == lkvc_pkg::ACT_PUT_HIT);
    assign w_is_new   = (i_cmd.act == lkvc_pkg::ACT_PUT_NEW);
    assign w_is_evict = (i_cmd.act == lkvc_pkg::ACT_PUT_EVICT);
    assign w_is_put   = (i_cmd.act == lkvc_pkg::ACT_PUT_HIT) || w_is_new || w_is_evict;
    assign w_touch    = i_cmd.apply && (w_is_hit || w_is_new || w_is_evict);

    always_comb begin
        priority if (w_is_hit) begin
            w_slot = r_hit_idx;
        end else if (w_is_new) begin
            w_slot = r_free_idx;
        end else begin
            w_slot = r_victim_idx;
        end
    end

    // on a hit, entries more recent than the touched one age by one; on an insert all other valid entries do
    assign w_thr = w_is_hit ? {1'b0, r_rank[r_hit_idx]} : (IW+1)'(ENTRIES);

    // value memory: read on capture, write on put update
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_q <= r_mem[w_match_idx];
        end
        if (i_cmd.apply && w_is_put) begin
            r_mem[w_slot] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_req_op;
            r_key        <= i_req_key;
            r_value      <= i_req_value;
            r_hit        <= |w_match;
            r_hit_idx    <= w_match_idx;
            r_free_idx   <= w_free_idx;
            r_victim_idx <= w_victim_idx;
        end
        if (i_cmd.apply && (w_is_new || w_is_evict)) begin
            r_key_store[w_slot] <= r_key;
        end
        if (i_cmd.apply) begin
            o_hit     <= r_hit;
            o_evicted <= w_is_evict;
            o_evicted_key <= w_is_evict ? r_key_store[r_victim_idx] : '0;
            unique case (i_cmd.act)
                lkvc_pkg::ACT_GET_HIT:  o_read_value <= r_rd_q;
                lkvc_pkg::ACT_GET_MISS: o_read_value <= '1;
                default:                o_read_value <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_cap_eff <= CW'(CAP_RS);
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && (r_count == '0)) begin
                r_cap_eff <= w_cap_clamped;
            end
            if (w_touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == w_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && ((IW+1)'(r_rank[i]) < w_thr)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end
            if (i_cmd.apply && w_is_new) begin
                r_valid[r_free_idx] <= 1'b1;
                r_count             <= r_count + CW'(1);
            end
        end
    end

    assign o_status.op   = r_op;
    assign o_status.hit  = r_hit;
    assign o_status.full = (r_count >= r_cap_eff);

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap_eff)
        else $error("entry count above capacity");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count disagrees with valid entries");

    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && w_is_new |-> !r_valid[r_free_idx])
        else $error("insert into an occupied slot");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && w_is_evict |-> r_valid[r_victim_idx])
        else $error("eviction of an empty slot");

endmodule

### rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: controller, datapath and channel hookup.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if, lkvc_cfg_if, lkvc_ctrl, lkvc_dpath.

// Fully associative key/value cache with least-recently-used replacement. When a
// request is transferred, the key is compared against all tags at once and the
// value memory is read; once the result register is free or being emptied, the
// recency ranks, tag store and value memory are updated and the result register
// loaded. The request port is not ready again until that update is done, so a new
// request is not taken before the last one is through. A finished result waits in
// the output register while the next request is taken in. No clearing pass runs
// after reset; the cache is usable as soon as reset ends. Capacity writes are always
// taken but change the capacity only while the cache is empty; 0 acts as 1 and
// values above ENTRIES act as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES     = lkvc_pkg::ENTRIES,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);

    lkvc_pkg::t_cmd    w_cmd;
    lkvc_pkg::t_status w_status;

    assign i_cfg.ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lkvc_dpath #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_op      (i_req.op),
        .i_req_key     (i_req.key),
        .i_req_value   (i_req.value),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );

endmodule
